// ===== hdl/sine_cosine_minimax_top_defines.svh =====
// ----------------------------------------------------------------------------
// sine_cosine_minimax_top_defines
// assertion macros shared by the checker of the sine/cosine block
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_MINIMAX_TOP_DEFINES_SVH
`define SINE_COSINE_MINIMAX_TOP_DEFINES_SVH

// check sampled on clk, switched off while rst_n is low
`define SCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds through reset
`define SCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// scm_pkg
// shared types, constants and the rounded fixed-point multiply
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int IFB                 = 30;   // internal fraction bits
  localparam int ANGLE_W             = 32;
  localparam int DEF_ANGLE_FRAC_BITS = 24;
  localparam int DEF_OUT_FRAC_BITS   = 16;
  localparam int QW                  = 34;   // internal signed word
  localparam int REM_W               = 33;   // reduced remainder, below two pi
  localparam int HORNER_STEPS        = 5;

  typedef logic signed [QW-1:0] q_t;

  localparam logic [63:0] PI_Q     = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q = 64'd6746518852;

  localparam q_t PI_S      = 34'sd3373259426;
  localparam q_t HALF_PI_S = 34'sd1686629713;

  // first Horner value of each polynomial
  localparam q_t SIN_INIT = -34'sd26;
  localparam q_t COS_INIT = -34'sd280;

  // constants added after each multiply by the squared angle
  localparam q_t SIN_COEF [HORNER_STEPS] = '{
    34'sd2956, -34'sd213040, 34'sd8947846, -34'sd178956974, 34'sd1073741824
  };
  localparam q_t COS_COEF [HORNER_STEPS] = '{
    34'sd26586, -34'sd1491253, 34'sd44739212, -34'sd536870912, 34'sd1073741824
  };

  // product of two values with IFB fraction bits, rounded half away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] prod;
    logic [2*QW-1:0] rnd;
    logic [QW-1:0]   mag;
    ma   = a[QW-1] ? -a : a;
    mb   = b[QW-1] ? -b : b;
    prod = (2*QW)'(ma) * (2*QW)'(mb);
    rnd  = (prod + ((2*QW)'(1) << (IFB - 1))) >> IFB;
    mag  = rnd[QW-1:0];
    return (a[QW-1] ^ b[QW-1]) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== hdl/scm_reduce_cell.sv =====
// ----------------------------------------------------------------------------
// scm_reduce_cell
// one restoring step of the remainder by two pi, shifted by a fixed amount
// ----------------------------------------------------------------------------
module scm_reduce_cell
  import scm_pkg::*;
#(
  parameter int DW    = 39,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          up_valid,
  input  logic [DW-1:0] up_rem,
  input  logic          up_neg,
  output logic          valid_r,
  output logic [DW-1:0] rem_r,
  output logic          neg_r
);

  localparam logic [DW-1:0] DIV = DW'(TWO_PI_Q << SHIFT);

  logic [DW-1:0] rem_nxt;

  assign rem_nxt = (up_rem >= DIV) ? (up_rem - DIV) : up_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      rem_r <= rem_nxt;
      neg_r <= up_neg;
    end
  end

endmodule

// ===== hdl/scm_fold_cell.sv =====
// ----------------------------------------------------------------------------
// scm_fold_cell
// centers the remainder on zero, restores the sign, folds into half pi
// ----------------------------------------------------------------------------
module scm_fold_cell
  import scm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             up_valid,
  input  logic [REM_W-1:0] up_rem,
  input  logic             up_neg,
  output logic             valid_r,
  output q_t               y_r,
  output logic             flip_r
);

  q_t   r_s;
  q_t   y0;
  q_t   y_nxt;
  logic flip_nxt;

  always_comb begin
    r_s = $signed({1'b0, up_rem});
    y0  = up_neg ? (PI_S - r_s) : (r_s - PI_S);
    priority if (y0 > HALF_PI_S) begin
      y_nxt    = PI_S - y0;
      flip_nxt = 1'b1;
    end else if (y0 < -HALF_PI_S) begin
      y_nxt    = -PI_S - y0;
      flip_nxt = 1'b1;
    end else begin
      y_nxt    = y0;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      y_r    <= y_nxt;
      flip_r <= flip_nxt;
    end
  end

endmodule

// ===== hdl/scm_horner_cell.sv =====
// ----------------------------------------------------------------------------
// scm_horner_cell
// one Horner step of both polynomials, sine and cosine lanes side by side
// ----------------------------------------------------------------------------
module scm_horner_cell
  import scm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic up_valid,
  input  q_t   up_sp,
  input  q_t   up_cp,
  input  q_t   up_y,
  input  q_t   up_y2,
  input  logic up_flip,
  output logic valid_r,
  output q_t   sp_r,
  output q_t   cp_r,
  output q_t   y_r,
  output q_t   y2_r,
  output logic flip_r
);

  q_t sp_nxt;
  q_t cp_nxt;

  assign sp_nxt = qmul(up_sp, up_y2) + SIN_COEF[IDX];
  assign cp_nxt = qmul(up_cp, up_y2) + COS_COEF[IDX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      sp_r   <= sp_nxt;
      cp_r   <= cp_nxt;
      y_r    <= up_y;
      y2_r   <= up_y2;
      flip_r <= up_flip;
    end
  end

endmodule

// ===== hdl/scm_out_cell.sv =====
// ----------------------------------------------------------------------------
// scm_out_cell
// last odd multiply for sine, cosine sign, rounding and saturation
// ----------------------------------------------------------------------------
module scm_out_cell
  import scm_pkg::*;
#(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
  localparam int OW           = OUT_FRAC_BITS + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          up_valid,
  input  q_t            up_sp,
  input  q_t            up_cp,
  input  q_t            up_y,
  input  logic          up_flip,
  output logic          valid_r,
  output logic [OW-1:0] sine_r,
  output logic [OW-1:0] cosine_r
);

  localparam int RS = IFB - OUT_FRAC_BITS;
  localparam logic [QW-1:0] RND = QW'((RS > 0) ? (64'd1 << ((RS > 0) ? RS - 1 : 0)) : 64'd0);
  localparam logic [QW-1:0] LIM = QW'(64'd1 << OUT_FRAC_BITS);

  function automatic logic [OW-1:0] to_out(input q_t v);
    logic [QW-1:0] m;
    logic [QW-1:0] r;
    m = v[QW-1] ? -v : v;
    r = (m + RND) >> RS;
    if (r > LIM) r = LIM;
    return v[QW-1] ? OW'(-r) : OW'(r);
  endfunction

  q_t            s_val;
  q_t            c_val;
  logic [OW-1:0] sine_nxt;
  logic [OW-1:0] cosine_nxt;

  assign s_val      = qmul(up_sp, up_y);
  assign c_val      = up_flip ? -up_cp : up_cp;
  assign sine_nxt   = to_out(s_val);
  assign cosine_nxt = to_out(c_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      sine_r   <= sine_nxt;
      cosine_r <= cosine_nxt;
    end
  end

endmodule

// ===== hdl/sine_cosine_minimax_top.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_minimax_top
// pipelined sine and cosine of a fixed-point angle by minimax polynomials
// ----------------------------------------------------------------------------
// Takes one angle beat per clock and returns one sine/cosine beat per angle, in
// order. With the output taken every cycle a new angle enters every cycle; an
// angle goes from input beat to output beat through the whole cell chain: one
// input cell, 31 - ANGLE_FRAC_BITS restoring cells that take the angle modulo
// two pi, one fold cell, one squaring cell, five Horner cells and the output
// cell. Every cell is a register stage that loads when it is empty or when the
// cell after it moves on, so a stalled output holds only the cells behind it
// that are full, and empty slots in the chain close up while the output waits.
// ----------------------------------------------------------------------------
module sine_cosine_minimax_top
  import scm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS,
  localparam int OUT_W          = OUT_FRAC_BITS + 2,
  localparam int OUT_TDATA_W    = ((2 * OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ANGLE_W-1:0]     in_tdata,    // angle
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // sine, cosine, zero fill
);

  // chain geometry
  localparam int RED_STAGES = 31 - ANGLE_FRAC_BITS;  // quotient bits of the reduction
  localparam int DW         = 63 - ANGLE_FRAC_BITS;  // widened angle plus pi
  localparam int S_FOLD     = RED_STAGES + 1;
  localparam int S_SQ       = RED_STAGES + 2;
  localparam int S_H0       = RED_STAGES + 3;
  localparam int S_OUT      = S_H0 + HORNER_STEPS;
  localparam int N_STG      = S_OUT + 1;

  // per-stage valid and load enable
  logic vld [N_STG];
  logic en  [N_STG];

  // a stage may load when empty or when the next stage loads
  for (genvar g = 0; g < N_STG - 1; g++) begin : g_en
    assign en[g] = !vld[g] || en[g+1];
  end
  assign en[N_STG-1] = !vld[N_STG-1] || out_tready;
  assign in_tready   = en[0];

  // input cell: magnitude, widened to internal fraction bits, plus pi
  // so the restoring steps round the quotient to nearest, ties outward
  logic [ANGLE_W-1:0] amag;
  logic [DW-1:0]      rem_nxt;
  logic [DW-1:0]      rem_a [RED_STAGES+1];
  logic               neg_a [RED_STAGES+1];
  logic               in_vld_r;
  logic [DW-1:0]      in_rem_r;
  logic               in_neg_r;

  assign amag    = in_tdata[ANGLE_W-1] ? -in_tdata : in_tdata;
  assign rem_nxt = (DW'(amag) << (IFB - ANGLE_FRAC_BITS)) + DW'(PI_Q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en[0]) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_tvalid) begin
      in_rem_r <= rem_nxt;
      in_neg_r <= in_tdata[ANGLE_W-1];
    end
  end

  assign vld[0]   = in_vld_r;
  assign rem_a[0] = in_rem_r;
  assign neg_a[0] = in_neg_r;

  // restoring cells, largest multiple of two pi first
  for (genvar g = 0; g < RED_STAGES; g++) begin : g_red
    scm_reduce_cell #(
      .DW    (DW),
      .SHIFT (RED_STAGES - 1 - g)
    ) u_red (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en[g+1]),
      .up_valid (vld[g]),
      .up_rem   (rem_a[g]),
      .up_neg   (neg_a[g]),
      .valid_r  (vld[g+1]),
      .rem_r    (rem_a[g+1]),
      .neg_r    (neg_a[g+1])
    );
  end

  // fold into plus or minus half pi
  q_t   fold_y;
  logic fold_flip;

  scm_fold_cell u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[S_FOLD]),
    .up_valid (vld[S_FOLD-1]),
    .up_rem   (rem_a[RED_STAGES][REM_W-1:0]),
    .up_neg   (neg_a[RED_STAGES]),
    .valid_r  (vld[S_FOLD]),
    .y_r      (fold_y),
    .flip_r   (fold_flip)
  );

  // squaring cell feeds the Horner chain
  q_t   sp_a   [HORNER_STEPS+1];
  q_t   cp_a   [HORNER_STEPS+1];
  q_t   y_a    [HORNER_STEPS+1];
  q_t   y2_a   [HORNER_STEPS+1];
  logic flip_a [HORNER_STEPS+1];
  logic sq_vld_r;
  q_t   sq_y_r;
  q_t   sq_y2_r;
  logic sq_flip_r;

  assign sp_a[0] = SIN_INIT;
  assign cp_a[0] = COS_INIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en[S_SQ]) begin
      sq_vld_r <= vld[S_FOLD];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SQ] && vld[S_FOLD]) begin
      sq_y_r    <= fold_y;
      sq_y2_r   <= qmul(fold_y, fold_y);
      sq_flip_r <= fold_flip;
    end
  end

  assign vld[S_SQ]  = sq_vld_r;
  assign y_a[0]     = sq_y_r;
  assign y2_a[0]    = sq_y2_r;
  assign flip_a[0]  = sq_flip_r;

  // Horner steps, one coefficient per cell
  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_hrn
    scm_horner_cell #(
      .IDX (g)
    ) u_hrn (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en[S_H0+g]),
      .up_valid (vld[S_H0+g-1]),
      .up_sp    (sp_a[g]),
      .up_cp    (cp_a[g]),
      .up_y     (y_a[g]),
      .up_y2    (y2_a[g]),
      .up_flip  (flip_a[g]),
      .valid_r  (vld[S_H0+g]),
      .sp_r     (sp_a[g+1]),
      .cp_r     (cp_a[g+1]),
      .y_r      (y_a[g+1]),
      .y2_r     (y2_a[g+1]),
      .flip_r   (flip_a[g+1])
    );
  end

  // output register
  logic [OUT_W-1:0] sine_q;
  logic [OUT_W-1:0] cosine_q;

  scm_out_cell #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en[S_OUT]),
    .up_valid (vld[S_OUT-1]),
    .up_sp    (sp_a[HORNER_STEPS]),
    .up_cp    (cp_a[HORNER_STEPS]),
    .up_y     (y_a[HORNER_STEPS]),
    .up_flip  (flip_a[HORNER_STEPS]),
    .valid_r  (vld[S_OUT]),
    .sine_r   (sine_q),
    .cosine_r (cosine_q)
  );

  assign out_tvalid = vld[S_OUT];
  assign out_tdata  = OUT_TDATA_W'({cosine_q, sine_q});

endmodule

// ===== hdl/scm_checker.sv =====
// ----------------------------------------------------------------------------
// scm_checker
// port-level checks of the sine/cosine block, bound to the top level
// ----------------------------------------------------------------------------
`include "sine_cosine_minimax_top_defines.svh"

module scm_checker
  import scm_pkg::*;
#(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
  localparam int OUT_W        = OUT_FRAC_BITS + 2,
  localparam int OUT_TDATA_W  = ((2 * OUT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int LIM  = 1 << OUT_FRAC_BITS;
  localparam int HALF = LIM / 2;

  logic signed [OUT_W-1:0] sine_s;
  logic signed [OUT_W-1:0] cosine_s;

  assign sine_s   = $signed(out_tdata[OUT_W-1:0]);
  assign cosine_s = $signed(out_tdata[2*OUT_W-1:OUT_W]);

  // stalled result beat is held
  `SCM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "output beat changed while stalled")

  // saturation keeps both results within plus or minus one
  `SCM_ASSERT(a_out_range, out_tvalid |-> sine_s <= LIM && sine_s >= -LIM && cosine_s <= LIM && cosine_s >= -LIM, "result outside unit range")

  // on the unit circle one of the two is at least one half in magnitude
  `SCM_ASSERT(a_out_circle, out_tvalid |-> sine_s >= HALF || sine_s <= -HALF || cosine_s >= HALF || cosine_s <= -HALF, "sine and cosine both near zero")

  // reset empties the chain and opens the input
  `SCM_ASSERT_RST(a_reset, !rst_n |=> !out_tvalid && in_tready, "chain not empty after reset")

endmodule

bind sine_cosine_minimax_top scm_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_scm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
